@@ rtl/adsr_pkg.sv @@
// Package for the ADSR envelope amplitude block: register indexes, reset values,
// pipeline stage records and the shared restoring division step.
// Used by adsr_envelope_amplitude; depends on nothing else.
package adsr_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int TICK_W = 24;
  localparam int LVL_W = 15;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [TICK_W-1:0] ATTACK_RST  = 24'd12960;
  localparam logic [TICK_W-1:0] DECAY_RST   = 24'd40800;
  localparam logic [TICK_W-1:0] RELEASE_RST = 24'd19200;
  localparam logic [LVL_W-1:0]  PEAK_RST    = 15'd22938;
  localparam logic [LVL_W-1:0]  HOLD_RST    = 15'd16384;
  localparam logic [LVL_W-1:0]  FLOOR_RST   = 15'd33;

  // Held-curve divider stage: partial remainder, remaining dividend bits,
  // quotient so far, divisor and how the quotient is applied to the base.
  typedef struct packed {
    logic [23:0] p;
    logic [14:0] lo;
    logic [14:0] q;
    logic [23:0] dv;
    logic [14:0] base;
    logic        neg;
  } hd_t;

  // Release quotient divider stage (elapsed release ticks over release length).
  typedef struct packed {
    logic [23:0] p;
    logic [15:0] lo;
    logic [15:0] q;
  } rd_t;

  // Per-request control flags.
  typedef struct packed {
    logic held;
    logic zero;
    logic sat;
  } ctl_t;

  // Fractional release divider stage, carrying the held value and integer drop.
  typedef struct packed {
    logic [23:0]        p;
    logic [14:0]        lo;
    logic [14:0]        q;
    logic signed [16:0] hval;
    logic [30:0]        qh;
    ctl_t               c;
  } fd_t;

  // One restoring division step: returns the new remainder and the quotient bit.
  function automatic logic [24:0] div_step(logic [23:0] p, logic b, logic [23:0] dv);
    logic [24:0] t;
    logic [24:0] r;
    t = {p, b};
    if (t >= {1'b0, dv}) begin
      r = {24'(t - {1'b0, dv}), 1'b1};
    end else begin
      r = {t[23:0], 1'b0};
    end
    return r;
  endfunction

endpackage

@@ rtl/adsr_envelope_amplitude.sv @@
// ADSR envelope amplitude, computed in a pipeline from accepted request to result.
// Throughput one request per cycle unless stalled; the depth is set by two restoring
// dividers (16 plus 15 quotient bits) on the release path, one bit per stage.
// The whole pipeline advances together and holds while the result is not taken.
// Synchronous reset clears all valid bits and loads the register reset values.
// Depends on adsr_pkg.
module adsr_envelope_amplitude #(
  parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adsr_pkg::TICK_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [TIME_BITS-1:0]           now_time,
  input  logic [TIME_BITS-1:0]           note_on_time,
  input  logic [TIME_BITS-1:0]           note_off_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [adsr_pkg::LVL_W-1:0]     amplitude
);

  localparam int NST = 35;
  localparam int CW = ((TIME_BITS > 24) ? TIME_BITS : 24) + 1;
  localparam int SW = ((TIME_BITS > 40) ? TIME_BITS : 40) + 1;

  logic [23:0] attack_ticks, decay_ticks, release_ticks;
  logic [14:0] peak_level, hold_level, floor_level;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ticks  <= adsr_pkg::ATTACK_RST;
      decay_ticks   <= adsr_pkg::DECAY_RST;
      release_ticks <= adsr_pkg::RELEASE_RST;
      peak_level    <= adsr_pkg::PEAK_RST;
      hold_level    <= adsr_pkg::HOLD_RST;
      floor_level   <= adsr_pkg::FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        adsr_pkg::REG_ATTACK:  attack_ticks  <= cfg_data;
        adsr_pkg::REG_DECAY:   decay_ticks   <= cfg_data;
        adsr_pkg::REG_RELEASE: release_ticks <= cfg_data;
        adsr_pkg::REG_PEAK:    peak_level    <= cfg_data[14:0];
        adsr_pkg::REG_HOLD:    hold_level    <= cfg_data[14:0];
        adsr_pkg::REG_FLOOR:   floor_level   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data; the whole pipe moves when the end is free.
  logic [NST-1:0] vld;
  logic           en;

  assign en        = !vld[NST-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // Stage A: elapsed times since key press and release.
  logic [TIME_BITS-1:0] a_life, a_rel;
  logic                 a_held;

  always_ff @(posedge clk) begin
    if (en) begin
      a_life <= now_time - note_on_time;
      a_rel  <= now_time - note_off_time;
      a_held <= note_on_time > note_off_time;
    end
  end

  // Stage B: pick the phase, form the held-curve dividend, set up the release.
  logic [CW-1:0] life_x, span_x;
  logic          atk, dec;
  logic [14:0]   dmag;
  logic [23:0]   mop_a;
  logic [14:0]   mop_b;
  logic [38:0]   hnum;
  logic [SW-1:0] rel_s, rel_lim;
  logic [39:0]   rel_x;

  adsr_pkg::hd_t  hs [0:16];
  adsr_pkg::rd_t  rs [0:16];
  adsr_pkg::ctl_t cs [0:16];

  assign life_x  = CW'(a_life);
  assign atk     = life_x <= CW'(attack_ticks);
  assign span_x  = life_x - CW'(attack_ticks);
  assign dec     = span_x <= CW'(decay_ticks);
  assign dmag    = (peak_level >= hold_level) ? (peak_level - hold_level)
                                              : (hold_level - peak_level);
  assign rel_s   = SW'(a_rel);
  assign rel_lim = SW'({release_ticks, 16'd0});
  assign rel_x   = 40'(a_rel);

  always_comb begin
    if (atk && attack_ticks != '0) begin
      mop_a = life_x[23:0];
      mop_b = peak_level;
    end else if (!atk && dec) begin
      mop_a = span_x[23:0];
      mop_b = dmag;
    end else begin
      mop_a = '0;
      mop_b = '0;
    end
  end

  assign hnum = 39'(mop_a) * 39'(mop_b);

  always_ff @(posedge clk) begin
    if (en) begin
      hs[0].p  <= hnum[38:15];
      hs[0].lo <= hnum[14:0];
      hs[0].q  <= '0;
      // Zero attack length at time zero gives the peak; sustain gives the hold.
      if (atk) begin
        hs[0].dv   <= (attack_ticks == '0) ? 24'd1 : attack_ticks;
        hs[0].base <= (attack_ticks == '0) ? peak_level : 15'd0;
        hs[0].neg  <= 1'b0;
      end else if (dec) begin
        hs[0].dv   <= decay_ticks;
        hs[0].base <= peak_level;
        hs[0].neg  <= hold_level < peak_level;
      end else begin
        hs[0].dv   <= 24'd1;
        hs[0].base <= hold_level;
        hs[0].neg  <= 1'b0;
      end
      rs[0].p     <= rel_x[39:16];
      rs[0].lo    <= rel_x[15:0];
      rs[0].q     <= '0;
      cs[0].held  <= a_held;
      cs[0].zero  <= !a_held && (release_ticks == '0);
      cs[0].sat   <= (rel_s >= rel_lim) && (hold_level != '0);
    end
  end

  // Sixteen division stages: release quotient, and held curve in the first 15.
  for (genvar k = 0; k < 16; k++) begin : g_div1
    logic [24:0] rn;
    assign rn = adsr_pkg::div_step(rs[k].p, rs[k].lo[15], release_ticks);

    always_ff @(posedge clk) begin
      if (en) begin
        rs[k+1].p  <= rn[24:1];
        rs[k+1].lo <= {rs[k].lo[14:0], 1'b0};
        rs[k+1].q  <= {rs[k].q[14:0], rn[0]};
        cs[k+1]    <= cs[k];
      end
    end

    if (k < 15) begin : g_hstep
      logic [24:0]   hn;
      adsr_pkg::hd_t hnx;
      assign hn = adsr_pkg::div_step(hs[k].p, hs[k].lo[14], hs[k].dv);

      // Next stage record: shifted dividend, new remainder and quotient bit.
      always_comb begin
        hnx    = hs[k];
        hnx.p  = hn[24:1];
        hnx.lo = {hs[k].lo[13:0], 1'b0};
        hnx.q  = {hs[k].q[13:0], hn[0]};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          hs[k+1] <= hnx;
        end
      end
    end else begin : g_hhold
      always_ff @(posedge clk) begin
        if (en) begin
          hs[k+1] <= hs[k];
        end
      end
    end
  end

  // Stage M: held value, integer part of the drop, fractional dividend.
  adsr_pkg::fd_t      fs [0:15];
  logic [38:0]        rh;
  logic signed [16:0] hb, hq;

  assign rh = 39'(rs[16].p) * 39'(hold_level);
  assign hb = $signed({2'b00, hs[16].base});
  assign hq = $signed({2'b00, hs[16].q});

  always_ff @(posedge clk) begin
    if (en) begin
      fs[0].p    <= rh[38:15];
      fs[0].lo   <= rh[14:0];
      fs[0].q    <= '0;
      fs[0].hval <= hs[16].neg ? (hb - hq) : (hb + hq);
      fs[0].qh   <= 31'(rs[16].q) * 31'(hold_level);
      fs[0].c    <= cs[16];
    end
  end

  // Fifteen division stages for the fractional part of the drop.
  for (genvar k = 0; k < 15; k++) begin : g_div2
    logic [24:0]   fn;
    adsr_pkg::fd_t fnx;
    assign fn = adsr_pkg::div_step(fs[k].p, fs[k].lo[14], release_ticks);

    // Next stage record: shifted dividend, new remainder and quotient bit.
    always_comb begin
      fnx    = fs[k];
      fnx.p  = fn[24:1];
      fnx.lo = {fs[k].lo[13:0], 1'b0};
      fnx.q  = {fs[k].q[13:0], fn[0]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fs[k+1] <= fnx;
      end
    end
  end

  // Output stage: subtract the drop after release (zero if no release length), apply the floor and clamp.
  logic [32:0]        drop;
  logic signed [33:0] amp;

  assign drop = fs[15].c.sat ? 33'd65536 : (33'(fs[15].qh) + 33'(fs[15].q));

  always_comb begin
    if (fs[15].c.held) begin
      amp = 34'(fs[15].hval);
    end else if (fs[15].c.zero) begin
      amp = '0;
    end else begin
      amp = 34'(fs[15].hval) - $signed({1'b0, drop});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (amp <= $signed({19'd0, floor_level})) begin
        amplitude <= '0;
      end else if (amp > $signed(34'd32767)) begin
        amplitude <= 15'h7fff;
      end else begin
        amplitude <= amp[14:0];
      end
    end
  end

endmodule
